/* design/nta_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg: shared types and constants of the neighbor table aging unit
// Command format passed from the front part to the table part, and the
// fixed field widths of the table.
// ----------------------------------------------------------------------------
package nta_pkg;

	// Input operation codes.
	localparam logic OP_HELLO = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Field widths.
	localparam int unsigned PORT_W     = 2;
	localparam int unsigned ID_W       = 32;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned IVAL_W     = 16;
	localparam int unsigned ALIVE_W    = 18;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned EXPIRED_W  = 5;

	// The dead timer runs for this many hello intervals.
	localparam int unsigned DEAD_FACTOR = 3;

	// Saturation limit of the neighbor and expiry counters.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	// Command queue between front and table.
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Classified command kinds.
	typedef enum logic [2:0] {
		CMD_HELLO = 3'b001,
		CMD_TICK  = 3'b010,
		CMD_DROP  = 3'b100
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [PORT_W-1:0]   port;
		logic [ID_W-1:0]     id;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   mask;
		logic [ALIVE_W-1:0]  load;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage
`default_nettype wire

/* design/nta_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nta_in_if: input item channel
// Hello and tick items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nta_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  port;
	logic [31:0] neighbor_id;
	logic [31:0] source_ip;
	logic [31:0] neighbor_mask;
	logic [15:0] hello_interval;

	modport source (
		output valid, operation, port, neighbor_id, source_ip, neighbor_mask,
		       hello_interval,
		input  ready
	);

	modport sink (
		input  valid, operation, port, neighbor_id, source_ip, neighbor_mask,
		       hello_interval,
		output ready
	);
endinterface
`default_nettype wire

/* design/nta_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nta_out_if: result item channel
// One result item per input item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nta_out_if;
	logic       valid;
	logic       ready;
	logic       lsu_trigger;
	logic       known_neighbor;
	logic       table_full;
	logic [4:0] expired_count;

	modport source (
		output valid, lsu_trigger, known_neighbor, table_full, expired_count,
		input  ready
	);

	modport sink (
		input  valid, lsu_trigger, known_neighbor, table_full, expired_count,
		output ready
	);
endinterface
`default_nettype wire

/* design/neighbor_table_aging_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_table_aging_unit: routing neighbor table with dead timers
// Learns neighbors from hello items, reloads their dead timers, and ages
// and removes them on tick items.
// ----------------------------------------------------------------------------
//  Channel  Direction  Item
//  req      in         operation, port, neighbor_id, source_ip,
//                      neighbor_mask, hello_interval
//  rsp      out        lsu_trigger, known_neighbor, table_full, expired_count
//
// The table part handles each item in turn: take a command from the queue,
// evaluate every cell in parallel, then apply the update and load the result.
// The next command is taken only once the apply step has loaded the result.
// A two-entry command queue keeps the input open while the table works or
// while a result waits on rsp.ready; a waiting result holds the apply cycle.
// Reset clears all valid bits and per-port counts at once; no clearing pass.
// ----------------------------------------------------------------------------
module neighbor_table_aging_unit #(
	parameter int unsigned NEIGHBOR_ENTRIES = 16,
	parameter int unsigned PORTS            = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	nta_in_if.sink     req,
	nta_out_if.source  rsp
);
	import nta_pkg::*;

	cmd_chan_t cmd_ch;
	logic      cmd_pop;

	// Intake and classification.
	nta_front #(
		.PORTS (PORTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cmd_ch  (cmd_ch),
		.cmd_pop (cmd_pop)
	);

	// Table and aging engine.
	nta_table #(
		.NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES),
		.PORTS            (PORTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.cmd_pop (cmd_pop),
		.rsp     (rsp)
	);
endmodule
`default_nettype wire

/* design/nta_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nta_front: item intake and classification
// Accepts input items, classifies them as hello, tick or dropped hello,
// computes the dead timer load and queues the command for the table.
// ----------------------------------------------------------------------------
module nta_front #(
	parameter int unsigned PORTS = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	nta_in_if.sink                 req,
	output nta_pkg::cmd_chan_t     cmd_ch,
	input  wire                    cmd_pop
);
	import nta_pkg::*;

	cmd_t                  fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	cmd_t                  cmd_new;
	logic                  push;

	// Room in the queue opens the input.
	assign req.ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign push      = req.valid && req.ready;

	// Classify the item and build the command.
	always_comb begin
		cmd_new.port = req.port;
		cmd_new.id   = req.neighbor_id;
		cmd_new.addr = req.source_ip;
		cmd_new.mask = req.neighbor_mask;
		cmd_new.load = ALIVE_W'(req.hello_interval) * ALIVE_W'(DEAD_FACTOR);
		if (req.operation == OP_TICK) begin
			cmd_new.kind = CMD_TICK;
		end else if (32'(req.port) >= PORTS) begin
			cmd_new.kind = CMD_DROP;
		end else begin
			cmd_new.kind = CMD_HELLO;
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (cmd_pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	assign cmd_ch.valid = (count_q != '0);
	assign cmd_ch.cmd   = fifo_q[rd_ptr_q];

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("command queue overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != '0)
		else $error("command popped from an empty queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> count_q == $past(count_q) + FIFO_CNT_W'(1))
		else $error("queue fill level missed a push");
`endif
endmodule
`default_nettype wire

/* design/nta_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nta_table: neighbor table and aging engine
// Holds the neighbor entries and per-port counts, carries out hello and tick
// commands in an evaluate cycle and an apply cycle, and holds the result in
// an output register.
// ----------------------------------------------------------------------------
module nta_table #(
	parameter int unsigned NEIGHBOR_ENTRIES = 16,
	parameter int unsigned PORTS            = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  nta_pkg::cmd_chan_t     cmd_ch,
	output logic                   cmd_pop,
	nta_out_if.source              rsp
);
	import nta_pkg::*;

	localparam int unsigned N     = NEIGHBOR_ENTRIES;
	localparam int unsigned CNT_W = $clog2(N + 1);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_EVAL  = 3'b010,
		B_APPLY = 3'b100
	} back_state_t;

	back_state_t          state_q;
	back_state_t          state_next;
	cmd_t                 cmd_q;

	// Table storage, one cell per entry.
	logic [N-1:0]         valid_q;
	logic [PORT_W-1:0]    port_q  [N];
	logic [ID_W-1:0]      id_q    [N];
	logic [ADDR_W-1:0]    addr_q  [N];
	logic [ADDR_W-1:0]    mask_q  [N];
	logic [ALIVE_W-1:0]   alive_q [N];
	logic [COUNT_W-1:0]   pcount_q [PORTS];

	// Evaluation results.
	logic [N-1:0]         hit_vec;
	logic [N-1:0]         free_vec;
	logic [N-1:0]         exp_vec;
	logic [N-1:0]         hit_oh_q;
	logic [N-1:0]         free_oh_q;
	logic [N-1:0]         exp_q;

	// Apply cycle signals.
	logic                 go;
	logic                 is_hello;
	logic                 is_tick;
	logic                 any_hit;
	logic                 any_free;
	logic [CNT_W-1:0]     n_exp;
	logic [N-1:0]         on_port [PORTS];
	logic [CNT_W-1:0]     port_exp [PORTS];

	// Output register.
	logic                 res_valid_q;
	logic                 res_lsu_q;
	logic                 res_known_q;
	logic                 res_full_q;
	logic [EXPIRED_W-1:0] res_expired_q;
	logic                 lsu_next;
	logic                 known_next;
	logic                 full_next;
	logic [EXPIRED_W-1:0] expired_next;

	// Sequencer: take a command, evaluate, apply when the result slot frees.
	assign cmd_pop = (state_q == B_IDLE) && cmd_ch.valid;
	assign go      = (state_q == B_APPLY) && (!res_valid_q || rsp.ready);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_ch.valid) begin
					state_next = B_EVAL;
				end
			end
			B_EVAL: begin
				state_next = B_APPLY;
			end
			B_APPLY: begin
				if (go) begin
					state_next = B_IDLE;
				end
			end
			default: begin
				state_next = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_ch.cmd;
		end
	end

	// Per-cell match, free and expiry flags.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_vec[i]  = valid_q[i] && (port_q[i] == cmd_q.port) && (id_q[i] == cmd_q.id);
			free_vec[i] = !valid_q[i];
			exp_vec[i]  = valid_q[i] && (alive_q[i] <= ALIVE_W'(1));
		end
	end

	// Keep only the lowest hit and the lowest free slot.
	always_ff @(posedge clk) begin
		if (state_q == B_EVAL) begin
			hit_oh_q  <= hit_vec & (~hit_vec + N'(1));
			free_oh_q <= free_vec & (~free_vec + N'(1));
			exp_q     <= exp_vec;
		end
	end

	assign is_hello = (cmd_q.kind == CMD_HELLO);
	assign is_tick  = (cmd_q.kind == CMD_TICK);
	assign any_hit  = |hit_oh_q;
	assign any_free = |free_oh_q;
	assign n_exp    = CNT_W'($countones(exp_q));

	// Expiring entries per port.
	always_comb begin
		for (int p = 0; p < PORTS; p++) begin
			for (int i = 0; i < N; i++) begin
				on_port[p][i] = (32'(port_q[i]) == p);
			end
			port_exp[p] = CNT_W'($countones(exp_q & on_port[p]));
		end
	end

	// Result of the command.
	always_comb begin
		lsu_next     = 1'b0;
		known_next   = 1'b0;
		full_next    = 1'b0;
		expired_next = '0;
		if (is_hello) begin
			known_next = any_hit;
			lsu_next   = !any_hit && any_free;
			full_next  = !any_hit && !any_free;
		end else if (is_tick) begin
			lsu_next     = (n_exp != '0);
			expired_next = (32'(n_exp) > 32'(COUNT_MAX)) ? COUNT_MAX : EXPIRED_W'(n_exp);
		end
	end

	// Valid bits and per-port neighbor counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int p = 0; p < PORTS; p++) begin
				pcount_q[p] <= '0;
			end
		end else if (go) begin
			if (is_hello && !any_hit && any_free) begin
				valid_q <= valid_q | free_oh_q;
				for (int p = 0; p < PORTS; p++) begin
					if ((32'(cmd_q.port) == p) && (pcount_q[p] < COUNT_MAX)) begin
						pcount_q[p] <= pcount_q[p] + COUNT_W'(1);
					end
				end
			end else if (is_tick) begin
				valid_q <= valid_q & ~exp_q;
				for (int p = 0; p < PORTS; p++) begin
					if (32'(pcount_q[p]) > 32'(port_exp[p])) begin
						pcount_q[p] <= pcount_q[p] - COUNT_W'(port_exp[p]);
					end else begin
						pcount_q[p] <= '0;
					end
				end
			end
		end
	end

	// Entry contents and dead timers.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (go && is_hello) begin
				if (any_hit) begin
					if (hit_oh_q[i]) begin
						alive_q[i] <= cmd_q.load;
					end
				end else if (free_oh_q[i]) begin
					port_q[i]  <= cmd_q.port;
					id_q[i]    <= cmd_q.id;
					addr_q[i]  <= cmd_q.addr;
					mask_q[i]  <= cmd_q.mask;
					alive_q[i] <= cmd_q.load;
				end
			end else if (go && is_tick) begin
				if (exp_q[i]) begin
					alive_q[i] <= '0;
				end else if (valid_q[i]) begin
					alive_q[i] <= alive_q[i] - ALIVE_W'(1);
				end
			end
		end
	end

	// Output register: loaded on apply, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_lsu_q     <= lsu_next;
			res_known_q   <= known_next;
			res_full_q    <= full_next;
			res_expired_q <= expired_next;
		end
	end

	assign rsp.valid          = res_valid_q;
	assign rsp.lsu_trigger    = res_lsu_q;
	assign rsp.known_neighbor = res_known_q;
	assign rsp.table_full     = res_full_q;
	assign rsp.expired_count  = res_expired_q;

`ifndef ASSERT_OFF
	a_pop_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == B_EVAL)
		else $error("popped command was not evaluated");

	a_single_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_APPLY |-> $onehot0(hit_oh_q) && $onehot0(free_oh_q))
		else $error("more than one slot selected");

	a_known_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_known_q && res_full_q))
		else $error("result both known and table full");

	a_expiry_update: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_expired_q != '0) |-> res_lsu_q)
		else $error("expiry without an update");
`endif
endmodule
`default_nettype wire
